// ===== hw/rtl/rhh_pkg.sv =====
// Shared types, constants and a helper function for the rainbow hue color generator.
`default_nettype none

package rhh_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_HUE_SPEED  = 3'd0;
  localparam logic [2:0] REG_HUE_STEP_X = 3'd1;
  localparam logic [2:0] REG_HUE_STEP_Y = 3'd2;
  localparam logic [2:0] REG_SATURATION = 3'd3;
  localparam logic [2:0] REG_BRIGHTNESS = 3'd4;

  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 3;

  localparam int PCT_MAX       = 100;
  localparam int RST_HUE_SPEED = 2560;
  localparam int RST_STEP_X    = 102;
  localparam int RST_STEP_Y    = 179;

  // A full turn is 360 * 256 = 45 * 2^11 phase units.
  localparam int BLOCK_SHIFT   = 11;
  localparam int HUE_BLOCKS    = 45;
  // 2^12 = 1 (mod 45), and the sign bit of a 31-bit quotient weighs 26 (mod 45).
  localparam int FOLD_SIGN     = 26;
  localparam int FOLD_RECIP    = 23302;
  localparam int FOLD_SHIFT    = 20;

  // One sector is 60 degrees = 15360 phase units = 15 * 2^10.
  localparam int SECTOR_UNITS  = 15360;
  localparam int SECTOR_SPAN   = 15;

  // Channel scale: value * 255 / (100 * 100 * 15360).
  localparam int CH_SCALE      = 255;
  localparam int CH_DENOM      = 153600000;
  localparam int CH_RECIP      = 7130;
  localparam int CH_SHIFT      = 32;

  localparam logic [2:0] SEC_RED_YEL  = 3'd0;
  localparam logic [2:0] SEC_YEL_GRN  = 3'd1;
  localparam logic [2:0] SEC_GRN_CYAN = 3'd2;
  localparam logic [2:0] SEC_CYAN_BLU = 3'd3;
  localparam logic [2:0] SEC_BLU_MAG  = 3'd4;
  localparam logic [2:0] SEC_MAG_RED  = 3'd5;

  typedef struct packed {
    logic signed [16:0] hue_speed;
    logic signed [15:0] hue_step_x;
    logic signed [15:0] hue_step_y;
    logic [13:0]        sat_bri;    // saturation * brightness
    logic [27:0]        base_m;     // m term on the common denominator
    logic [27:0]        full_lvl;   // C + m on the common denominator
  } cfg_t;

  typedef struct packed {
    logic [2:0]  sector;
    logic [13:0] ramp;              // distance into the sector, mirrored in odd sectors
  } hue_t;

  typedef struct packed {
    logic [2:0] sector;
    logic [3:0] rem;
  } sec_split_t;

  // Splits a hue in units of 1024 phase steps (0..89) into sector and position.
  function automatic sec_split_t split_sector(input logic [6:0] hi);
    sec_split_t res;
    res.sector = SEC_RED_YEL;
    if (hi >= 7'(5 * SECTOR_SPAN)) begin
      res.sector = SEC_MAG_RED;
    end else if (hi >= 7'(4 * SECTOR_SPAN)) begin
      res.sector = SEC_BLU_MAG;
    end else if (hi >= 7'(3 * SECTOR_SPAN)) begin
      res.sector = SEC_CYAN_BLU;
    end else if (hi >= 7'(2 * SECTOR_SPAN)) begin
      res.sector = SEC_GRN_CYAN;
    end else if (hi >= 7'(SECTOR_SPAN)) begin
      res.sector = SEC_YEL_GRN;
    end
    res.rem = 4'(hi - 7'(7'(res.sector) * 7'(SECTOR_SPAN)));
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rhh_cfg.sv =====
// Configuration registers and the color terms derived from them.
`default_nettype none

module rhh_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [rhh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rhh_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output rhh_pkg::cfg_t                          cfg_o
);

  logic signed [16:0] speed_r;
  logic signed [15:0] step_x_r;
  logic signed [15:0] step_y_r;
  logic [6:0]         sat_r;
  logic [6:0]         bri_r;
  logic [13:0]        sat_bri_r;
  logic [27:0]        base_m_r;
  logic [27:0]        full_r;
  logic [6:0]         pct_nxt;
  logic [13:0]        sat_bri_nxt;
  logic [27:0]        base_m_nxt;
  logic [27:0]        full_nxt;

  assign pct_nxt = (cfg_wdata[6:0] > 7'(rhh_pkg::PCT_MAX)) ? 7'(rhh_pkg::PCT_MAX)
                                                             : cfg_wdata[6:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r  <= 17'(rhh_pkg::RST_HUE_SPEED);
      step_x_r <= 16'(rhh_pkg::RST_STEP_X);
      step_y_r <= 16'(rhh_pkg::RST_STEP_Y);
      sat_r    <= 7'(rhh_pkg::PCT_MAX);
      bri_r    <= 7'(rhh_pkg::PCT_MAX);
    end else if (cfg_we) begin
      unique case (cfg_index)
        rhh_pkg::REG_HUE_SPEED:  speed_r  <= $signed(cfg_wdata);
        rhh_pkg::REG_HUE_STEP_X: step_x_r <= $signed(cfg_wdata[15:0]);
        rhh_pkg::REG_HUE_STEP_Y: step_y_r <= $signed(cfg_wdata[15:0]);
        rhh_pkg::REG_SATURATION: sat_r    <= pct_nxt;
        rhh_pkg::REG_BRIGHTNESS: bri_r    <= pct_nxt;
        default: ;
      endcase
    end
  end

  // The derived terms are registered from the configuration registers; base_m uses the registered sat_bri_r.
  assign sat_bri_nxt = 14'(sat_r) * 14'(bri_r);
  assign base_m_nxt  = 28'(14'(14'(bri_r) * 14'(rhh_pkg::PCT_MAX)) - sat_bri_r)
                       * 28'(rhh_pkg::SECTOR_UNITS);
  assign full_nxt    = 28'(bri_r) * 28'(rhh_pkg::PCT_MAX * rhh_pkg::SECTOR_UNITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_bri_r <= 14'(rhh_pkg::PCT_MAX * rhh_pkg::PCT_MAX);
      base_m_r  <= '0;
      full_r    <= 28'(rhh_pkg::CH_DENOM);
    end else begin
      sat_bri_r <= sat_bri_nxt;
      base_m_r  <= base_m_nxt;
      full_r    <= full_nxt;
    end
  end

  always_comb begin
    cfg_o.hue_speed  = speed_r;
    cfg_o.hue_step_x = step_x_r;
    cfg_o.hue_step_y = step_y_r;
    cfg_o.sat_bri    = sat_bri_r;
    cfg_o.base_m     = base_m_r;
    cfg_o.full_lvl   = full_r;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rhh_phase.sv =====
// Hue phase pipeline: phase sum, reduction modulo one turn, and sector split.
`default_nettype none

module rhh_phase (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  wire rhh_pkg::cfg_t       cfg_i,
  input  wire logic                in_valid,
  input  wire logic signed [15:0]  pos_x,
  input  wire logic signed [15:0]  pos_y,
  input  wire logic [31:0]         time_now,
  output logic                     hue_valid,
  output rhh_pkg::hue_t            hue_o
);

  logic [5:0] vld_r;

  logic signed [49:0] prod_t_r;
  logic signed [31:0] prod_x_r;
  logic signed [31:0] prod_y_r;
  logic signed [49:0] prod_t_nxt;
  logic signed [31:0] prod_x_nxt;
  logic signed [31:0] prod_y_nxt;

  logic signed [41:0] phase_sum;
  logic [30:0]        quo_r;
  logic [10:0]        low2_r;

  logic [13:0]        fold_nxt;
  logic [13:0]        fold_r;
  logic [10:0]        low3_r;

  logic [27:0]        recip_prod;
  logic [7:0]         est_r;
  logic [13:0]        fold4_r;
  logic [10:0]        low4_r;

  logic [13:0]        rem_full;
  logic [6:0]         hi_r;
  logic [9:0]         low5_r;

  rhh_pkg::sec_split_t split;
  logic [13:0]        pos_in_sec;
  logic [2:0]         sector_r;
  logic [13:0]        ramp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  // Stage 1: the three products.
  assign prod_t_nxt = $signed(cfg_i.hue_speed) * $signed({1'b0, time_now});
  assign prod_x_nxt = $signed(cfg_i.hue_step_x) * pos_x;
  assign prod_y_nxt = $signed(cfg_i.hue_step_y) * pos_y;

  // Stage 2: phase sum; the time term is floored by the arithmetic shift.
  assign phase_sum = 42'(prod_t_r >>> 8) + 42'(prod_x_r) + 42'(prod_y_r);

  // Stage 3: the quotient by 2^11 is folded in 12-bit chunks, since 2^12 is 1 modulo 45.
  assign fold_nxt = 14'(quo_r[11:0]) + 14'(quo_r[23:12]) + 14'(quo_r[29:24])
                    + (quo_r[30] ? 14'(rhh_pkg::FOLD_SIGN) : 14'd0);

  // Stage 4: quotient estimate of the folded value by 45, exact for this range.
  assign recip_prod = 28'(fold_r) * 28'(rhh_pkg::FOLD_RECIP);

  // Stage 5: remainder by 45 gives the hue in units of 2048, then one more bit of it.
  assign rem_full = fold4_r - 14'(14'(est_r) * 14'(rhh_pkg::HUE_BLOCKS));

  // Stage 6: sector and ramp.
  assign split      = rhh_pkg::split_sector(hi_r);
  assign pos_in_sec = {split.rem, low5_r};

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_t_r <= prod_t_nxt;
      prod_x_r <= prod_x_nxt;
      prod_y_r <= prod_y_nxt;
      quo_r    <= phase_sum[41:rhh_pkg::BLOCK_SHIFT];
      low2_r   <= phase_sum[rhh_pkg::BLOCK_SHIFT-1:0];
      fold_r   <= fold_nxt;
      low3_r   <= low2_r;
      est_r    <= recip_prod[rhh_pkg::FOLD_SHIFT +: 8];
      fold4_r  <= fold_r;
      low4_r   <= low3_r;
      hi_r     <= {rem_full[5:0], low4_r[10]};
      low5_r   <= low4_r[9:0];
      sector_r <= split.sector;
      ramp_r   <= split.sector[0] ? 14'(14'(rhh_pkg::SECTOR_UNITS) - pos_in_sec)
                                  : pos_in_sec;
    end
  end

  assign hue_valid    = vld_r[5];
  assign hue_o.sector = sector_r;
  assign hue_o.ramp   = ramp_r;

endmodule

`default_nettype wire

// ===== hw/rtl/rhh_div.sv =====
// Scales one channel level to 0..255 by a reciprocal estimate and one correction step.
`default_nettype none

module rhh_div (
  input  wire logic        clk,
  input  wire logic        adv,
  input  wire logic [27:0] level,
  output logic [7:0]       chan
);

  logic [35:0] scaled_r;
  logic [8:0]  est_r;
  logic [40:0] recip_prod;
  logic [35:0] resid;
  logic [8:0]  fixed;
  logic [7:0]  chan_r;

  // The estimate is never high and at most one low.
  assign recip_prod = 41'(level) * 41'(rhh_pkg::CH_RECIP);
  assign resid      = scaled_r - 36'(36'(est_r) * 36'(rhh_pkg::CH_DENOM));
  assign fixed      = est_r + ((resid >= 36'(rhh_pkg::CH_DENOM)) ? 9'd1 : 9'd0);

  always_ff @(posedge clk) begin
    if (adv) begin
      scaled_r <= 36'(level) * 36'(rhh_pkg::CH_SCALE);
      est_r    <= recip_prod[rhh_pkg::CH_SHIFT +: 9];
      chan_r   <= fixed[7:0];
    end
  end

  assign chan = chan_r;

endmodule

`default_nettype wire

// ===== hw/rtl/rhh_color.sv =====
// Color stages: chroma ramp product, channel selection by sector, and scaling to 8 bits.
`default_nettype none

module rhh_color (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv,
  input  wire rhh_pkg::cfg_t cfg_i,
  input  wire logic          hue_valid,
  input  wire rhh_pkg::hue_t hue_i,
  output logic               out_valid,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue
);

  logic [3:0]  vld_r;
  logic [27:0] xn_r;
  logic [2:0]  sector_r;
  logic [27:0] lvl_x;
  logic [27:0] lvl_r_nxt;
  logic [27:0] lvl_g_nxt;
  logic [27:0] lvl_b_nxt;
  logic [27:0] lvl_r_r;
  logic [27:0] lvl_g_r;
  logic [27:0] lvl_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[2:0], hue_valid};
    end
  end

  assign lvl_x = xn_r + cfg_i.base_m;

  always_comb begin
    unique case (sector_r)
      rhh_pkg::SEC_RED_YEL: begin
        lvl_r_nxt = cfg_i.full_lvl; lvl_g_nxt = lvl_x;          lvl_b_nxt = cfg_i.base_m;
      end
      rhh_pkg::SEC_YEL_GRN: begin
        lvl_r_nxt = lvl_x;          lvl_g_nxt = cfg_i.full_lvl; lvl_b_nxt = cfg_i.base_m;
      end
      rhh_pkg::SEC_GRN_CYAN: begin
        lvl_r_nxt = cfg_i.base_m;   lvl_g_nxt = cfg_i.full_lvl; lvl_b_nxt = lvl_x;
      end
      rhh_pkg::SEC_CYAN_BLU: begin
        lvl_r_nxt = cfg_i.base_m;   lvl_g_nxt = lvl_x;          lvl_b_nxt = cfg_i.full_lvl;
      end
      rhh_pkg::SEC_BLU_MAG: begin
        lvl_r_nxt = lvl_x;          lvl_g_nxt = cfg_i.base_m;   lvl_b_nxt = cfg_i.full_lvl;
      end
      default: begin
        lvl_r_nxt = cfg_i.full_lvl; lvl_g_nxt = cfg_i.base_m;   lvl_b_nxt = lvl_x;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xn_r     <= 28'(cfg_i.sat_bri) * 28'(hue_i.ramp);
      sector_r <= hue_i.sector;
      lvl_r_r  <= lvl_r_nxt;
      lvl_g_r  <= lvl_g_nxt;
      lvl_b_r  <= lvl_b_nxt;
    end
  end

  rhh_div u_div_red (
    .clk   (clk),
    .adv   (adv),
    .level (lvl_r_r),
    .chan  (red)
  );

  rhh_div u_div_green (
    .clk   (clk),
    .adv   (adv),
    .level (lvl_g_r),
    .chan  (green)
  );

  rhh_div u_div_blue (
    .clk   (clk),
    .adv   (adv),
    .level (lvl_b_r),
    .chan  (blue)
  );

  assign out_valid = vld_r[3];

endmodule

`default_nettype wire

// ===== hw/rtl/rainbow_hue_hsv_to_rgb.sv =====
// Top level of the rainbow hue color generator.
//
// Turns a pixel position and a time stamp into an RGB color whose hue runs with
// time and across the screen, at fixed saturation and brightness. The block is a
// ten-stage pipeline: it takes one item per clock while the result side is not
// stalled. Stall on the result side freezes every stage at once, so in_stall
// follows out_stall while a result is waiting; nothing is dropped or repeated.
// Configuration writes take effect once the derived terms are registered, and
// must only be made while no item is in flight.
`default_nettype none

module rainbow_hue_hsv_to_rgb (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [rhh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rhh_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic signed [15:0]              in_pos_x,
  input  wire logic signed [15:0]              in_pos_y,
  input  wire logic [31:0]                     in_time_now,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [7:0]                           out_red,
  output logic [7:0]                           out_green,
  output logic [7:0]                           out_blue
);

  rhh_pkg::cfg_t cfg;
  rhh_pkg::hue_t hue;
  logic          hue_valid;
  logic          adv;

  // The pipeline moves whenever the last stage is empty or being taken.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  rhh_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  rhh_phase u_phase (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .cfg_i     (cfg),
    .in_valid  (in_valid),
    .pos_x     (in_pos_x),
    .pos_y     (in_pos_y),
    .time_now  (in_time_now),
    .hue_valid (hue_valid),
    .hue_o     (hue)
  );

  rhh_color u_color (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .cfg_i     (cfg),
    .hue_valid (hue_valid),
    .hue_i     (hue),
    .out_valid (out_valid),
    .red       (out_red),
    .green     (out_green),
    .blue      (out_blue)
  );

endmodule

`default_nettype wire

// ===== sim/rhh_color_checker.sv =====
// Checker for the rainbow hue color generator: predicts each color and compares results.
`timescale 1ns / 1ps

module rhh_color_checker
  import rhh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic signed [15:0]    in_pos_x,
  input  logic signed [15:0]    in_pos_y,
  input  logic [31:0]           in_time_now,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [7:0]            out_red,
  input  logic [7:0]            out_green,
  input  logic [7:0]            out_blue,
  output int                    mismatch_count,
  output int                    colors_due
);

  localparam longint HUE_TURN = 6 * SECTOR_UNITS;
  // Keeps the log readable when the design is badly broken.
  localparam int REPORT_LIMIT = 100;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic signed [16:0] speed_q;
  logic signed [15:0] step_x_q;
  logic signed [15:0] step_y_q;
  logic [6:0]         sat_q;
  logic [6:0]         bri_q;

  rgb_t expected_colors[$];
  rgb_t want;

  function automatic logic [6:0] clamp_pct(input logic [CFG_DATA_W-1:0] data);
    logic [6:0] v;
    v = data[6:0];
    return (v > 7'(PCT_MAX)) ? 7'(PCT_MAX) : v;
  endfunction

  function automatic rgb_t predict_color(input logic signed [15:0] px,
                                         input logic signed [15:0] py,
                                         input logic [31:0] t);
    longint phase, hue, sector, ramp, sat_bri, full_c, ramp_x, base_m;
    longint lvl_r, lvl_g, lvl_b;
    rgb_t c;
    // The arithmetic shift of the signed product rounds toward minus infinity.
    phase = (longint'(speed_q) * longint'(t)) >>> 8;
    phase += longint'(step_x_q) * longint'(px) + longint'(step_y_q) * longint'(py);
    hue = phase % HUE_TURN;
    if (hue < 0) begin
      hue += HUE_TURN;
    end
    sector = hue / SECTOR_UNITS;
    ramp = hue % SECTOR_UNITS;
    if (sector % 2 == 1) begin
      ramp = SECTOR_UNITS - ramp;
    end
    sat_bri = longint'(sat_q) * longint'(bri_q);
    full_c = sat_bri * SECTOR_UNITS;
    ramp_x = sat_bri * ramp;
    base_m = (PCT_MAX * longint'(bri_q) - sat_bri) * SECTOR_UNITS;
    case (3'(sector))
      SEC_RED_YEL: begin
        lvl_r = full_c; lvl_g = ramp_x; lvl_b = 0;
      end
      SEC_YEL_GRN: begin
        lvl_r = ramp_x; lvl_g = full_c; lvl_b = 0;
      end
      SEC_GRN_CYAN: begin
        lvl_r = 0; lvl_g = full_c; lvl_b = ramp_x;
      end
      SEC_CYAN_BLU: begin
        lvl_r = 0; lvl_g = ramp_x; lvl_b = full_c;
      end
      SEC_BLU_MAG: begin
        lvl_r = ramp_x; lvl_g = 0; lvl_b = full_c;
      end
      default: begin
        lvl_r = full_c; lvl_g = 0; lvl_b = ramp_x;
      end
    endcase
    c.red   = 8'((lvl_r + base_m) * CH_SCALE / CH_DENOM);
    c.green = 8'((lvl_g + base_m) * CH_SCALE / CH_DENOM);
    c.blue  = 8'((lvl_b + base_m) * CH_SCALE / CH_DENOM);
    return c;
  endfunction

  task automatic check_channel(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      if (mismatch_count < REPORT_LIMIT) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
      mismatch_count++;
    end
  endtask

  initial begin
    mismatch_count = 0;
    colors_due = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      speed_q  = 17'(RST_HUE_SPEED);
      step_x_q = 16'(RST_STEP_X);
      step_y_q = 16'(RST_STEP_Y);
      sat_q    = 7'(PCT_MAX);
      bri_q    = 7'(PCT_MAX);
      expected_colors.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HUE_SPEED:  speed_q = cfg_wdata;
          REG_HUE_STEP_X: step_x_q = cfg_wdata[15:0];
          REG_HUE_STEP_Y: step_y_q = cfg_wdata[15:0];
          REG_SATURATION: sat_q = clamp_pct(cfg_wdata);
          REG_BRIGHTNESS: bri_q = clamp_pct(cfg_wdata);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_colors.push_back(predict_color(in_pos_x, in_pos_y, in_time_now));
      end
      if (out_valid && !out_stall) begin
        if (expected_colors.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT) begin
            $display("%0t: color with none expected, expected none, actual %0d/%0d/%0d",
                     $time, out_red, out_green, out_blue);
          end
          mismatch_count++;
        end else begin
          want = expected_colors.pop_front();
          check_channel("red", want.red, out_red);
          check_channel("green", want.green, out_green);
          check_channel("blue", want.blue, out_blue);
        end
      end
    end
    colors_due <= expected_colors.size();
  end

endmodule

// ===== sim/tb_rainbow_hue_hsv_to_rgb.sv =====
// Testbench top for the rainbow hue color generator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_rainbow_hue_hsv_to_rgb;
  import rhh_pkg::*;

  localparam int DRAIN_CYCLES = 16;
  localparam int CFG_SETTLE   = 4;
  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASES       = 16;
  localparam int PHASE_ITEMS  = 65;
  // Indexes past the register list; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic signed [15:0]    in_pos_x;
  logic signed [15:0]    in_pos_y;
  logic [31:0]           in_time_now;
  logic                  out_valid;
  logic                  out_stall;
  logic [7:0]            out_red;
  logic [7:0]            out_green;
  logic [7:0]            out_blue;

  int mismatch_count;
  int colors_due;
  int idle_cycles;
  bit burst_mode;
  bit hold_req;

  rainbow_hue_hsv_to_rgb DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_time_now(in_time_now),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue)
  );

  rhh_color_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_time_now(in_time_now),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .mismatch_count(mismatch_count), .colors_due(colors_due)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_signed(input logic [CFG_DATA_W-1:0] lo,
                                                        input logic [CFG_DATA_W-1:0] hi,
                                                        input logic [CFG_DATA_W-1:0] rst);
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      2: return '0;
      3: return rst;
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_pct();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CFG_DATA_W'(PCT_MAX);
      2: return CFG_DATA_W'($urandom_range(PCT_MAX + 1, 127));
      3: return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(0, PCT_MAX));
    endcase
  endfunction

  task automatic send_pixel(input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic [31:0] t);
    int gap;
    gap = burst_mode ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= x;
    in_pos_y <= y;
    in_time_now <= t;
    do @(posedge clk); while (in_stall);
  endtask

  // Ends a run of items and waits until the pipeline is empty.
  task automatic drain_pipe();
    in_valid <= 1'b0;
    do @(posedge clk); while (colors_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    repeat (CFG_SETTLE) @(posedge clk);
  endtask

  task automatic configure_phase(input int phase);
    if (phase == 0) begin
      write_reg(REG_HUE_SPEED, 17'h10000);
      write_reg(REG_HUE_STEP_X, 17'h08000);
      write_reg(REG_HUE_STEP_Y, 17'h18000);
      write_reg(REG_SATURATION, '0);
      write_reg(REG_BRIGHTNESS, '0);
    end else if (phase == 1) begin
      write_reg(REG_HUE_SPEED, 17'h0FFFF);
      write_reg(REG_HUE_STEP_X, 17'h07FFF);
      write_reg(REG_HUE_STEP_Y, 17'h17FFF);
      write_reg(REG_SATURATION, CFG_DATA_W'(PCT_MAX));
      write_reg(REG_BRIGHTNESS, CFG_DATA_W'(PCT_MAX));
    end else begin
      write_reg(REG_HUE_SPEED, pick_signed(17'h10000, 17'h0FFFF, CFG_DATA_W'(RST_HUE_SPEED)));
      write_reg(REG_HUE_STEP_X, pick_signed(17'h08000, 17'h07FFF, CFG_DATA_W'(RST_STEP_X)));
      write_reg(REG_HUE_STEP_Y, pick_signed(17'h18000, 17'h17FFF, CFG_DATA_W'(RST_STEP_Y)));
      write_reg(REG_SATURATION, pick_pct());
      write_reg(REG_BRIGHTNESS, pick_pct());
      if ($urandom_range(0, 2) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                  CFG_DATA_W'($urandom));
      end
    end
    end_writes();
  endtask

  task automatic send_random_pixel();
    logic signed [15:0] x, y;
    logic [31:0] t;
    if ($urandom_range(0, 3) == 0) begin
      x = 16'($urandom_range(0, 800) - 400);
      y = 16'($urandom_range(0, 800) - 400);
    end else begin
      x = 16'($urandom);
      y = 16'($urandom);
    end
    t = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 5000)) : $urandom;
    send_pixel(x, y, t);
  endtask

  // Receiver: random stall runs, plus one long hold-off on request.
  initial begin
    int n;
    out_stall = 1'b0;
    hold_req = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int phase;
    int i;
    idle_cycles = 0;
    burst_mode = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_time_now = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Field extremes under the reset settings.
    send_pixel(16'sd0, 16'sd0, 32'd0);
    send_pixel(-16'sd32768, -16'sd32768, 32'd0);
    send_pixel(16'sd32767, 16'sd32767, 32'hFFFF_FFFF);
    send_pixel(-16'sd32768, 16'sd32767, 32'h8000_0000);
    send_pixel(16'sd32767, -16'sd32768, 32'h7FFF_FFFF);
    send_pixel(16'sh5555, 16'shAAAA, 32'h5555_AAAA);
    drain_pipe();

    // One degree per column: walk every sector, both wraps and a fractional step.
    // Saturation and brightness are written above 100 and must hold 100.
    write_reg(REG_HUE_SPEED, '0);
    write_reg(REG_HUE_STEP_X, 17'd256);
    write_reg(REG_HUE_STEP_Y, 17'd1);
    write_reg(REG_SATURATION, 17'h1FFFF);
    write_reg(REG_BRIGHTNESS, 17'd101);
    write_reg(REG_SPARE_FIRST, 17'h00005);
    write_reg(REG_SPARE_LAST, 17'h1FFFF);
    end_writes();
    send_pixel(16'sd0, 16'sd0, $urandom);
    send_pixel(16'sd59, 16'sd255, $urandom);
    send_pixel(16'sd60, 16'sd0, $urandom);
    send_pixel(16'sd119, 16'sd0, $urandom);
    send_pixel(16'sd120, 16'sd0, $urandom);
    send_pixel(16'sd180, 16'sd0, $urandom);
    send_pixel(16'sd240, 16'sd0, $urandom);
    send_pixel(16'sd300, 16'sd0, $urandom);
    send_pixel(16'sd359, 16'sd128, $urandom);
    send_pixel(16'sd360, 16'sd0, $urandom);
    send_pixel(-16'sd1, 16'sd0, $urandom);
    send_pixel(-16'sd360, -16'sd1, $urandom);
    drain_pipe();

    // Gray at full saturation loss, then black.
    write_reg(REG_SATURATION, 17'h00080);
    end_writes();
    send_pixel(16'sd30, 16'sd0, 32'd0);
    drain_pipe();
    write_reg(REG_SATURATION, 17'd50);
    write_reg(REG_BRIGHTNESS, '0);
    end_writes();
    send_pixel(16'sd90, 16'sd0, 32'd0);
    drain_pipe();

    // Most negative speed: the time term rounds toward minus infinity.
    write_reg(REG_HUE_SPEED, 17'h10000);
    write_reg(REG_HUE_STEP_X, '0);
    write_reg(REG_HUE_STEP_Y, '0);
    write_reg(REG_SATURATION, 17'd100);
    write_reg(REG_BRIGHTNESS, 17'd77);
    end_writes();
    send_pixel(16'sd0, 16'sd0, 32'd1);
    send_pixel(16'sd0, 16'sd0, 32'hFFFF_FFFF);
    send_pixel(16'sd0, 16'sd0, 32'd3);
    drain_pipe();

    for (phase = 0; phase < PHASES; phase++) begin
      configure_phase(phase);
      burst_mode = ($urandom_range(0, 4) == 0);
      if (phase == 5) begin
        // Sender keeps offering while the receiver holds off, so the pipe fills.
        burst_mode = 1'b1;
        hold_req = 1'b1;
      end
      for (i = 0; i < PHASE_ITEMS; i++) begin
        send_random_pixel();
      end
      drain_pipe();
    end

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
